/* rtl/cce_pkg.sv */
// Package for the complex Chebyshev evaluator: payload structs, datapath widths,
// register indexes and the control and status structs between the sequencer and the MAC.
// No dependencies.
package cce_pkg;

   localparam int IN_W   = 32;
   localparam int VAL_W  = 48;
   localparam int CNT_W  = 10;
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;
   localparam int HALF_W = 24;
   localparam int PART_W = HALF_W + 1;
   localparam int PROD_W = 2 * PART_W;
   localparam int ACC_W  = 2 * VAL_W + 2;

   localparam logic signed [IN_W-1:0] SCALE_RESET  = 32'sd33554432;
   localparam logic signed [IN_W-1:0] OFFSET_RESET = 32'sd16777216;
   localparam logic [CNT_W-1:0]       COUNT_RESET  = 10'd2;

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic [1:0] {
      REG_SCALE  = 2'd0,
      REG_OFFSET = 2'd1,
      REG_COUNT  = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      SHIFT_NONE,
      SHIFT_HALF,
      SHIFT_FULL
   } shift_type;

   typedef struct packed {
      logic signed [IN_W-1:0] point_real;
      logic signed [IN_W-1:0] point_imag;
   } req_payload_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value_real;
      logic signed [VAL_W-1:0] value_imag;
      logic                    overflow_flag;
   } rsp_payload_type;

   typedef struct packed {
      logic                     issue;
      logic                     load;
      logic signed [VAL_W-1:0]  load_prev;
      logic signed [PART_W-1:0] a_half;
      logic signed [PART_W-1:0] b_half;
      shift_type                shift_sel;
      logic                     dbl;
      logic                     neg;
   } mac_ctl_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    sat;
   } fin_type;

endpackage

/* rtl/cce_mac.sv */
// Shared multiply-accumulate unit of the complex Chebyshev evaluator: one registered
// 25x25 signed multiplier, a wide accumulator and the floor-and-saturate finish logic.
// Depends on cce_pkg.
module cce_mac
   import cce_pkg::*;
#(
   parameter int FRAC_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  mac_ctl_type ctl,
   output fin_type     fin
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     pvld_ff, pvld_in;
   shift_type                psh_ff, psh_in;
   logic                     pdbl_ff, pdbl_in;
   logic                     pneg_ff, pneg_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  ext;
   logic signed [ACC_W-1:0]  addend;
   logic signed [ACC_W-1:0]  load_ext;
   logic signed [ACC_W-1:0]  shifted;
   logic [ACC_W-VAL_W:0]     top_bits;

   always_comb begin
      prod_in = ctl.a_half * ctl.b_half;
      pvld_in = ctl.issue;
      psh_in  = ctl.shift_sel;
      pdbl_in = ctl.dbl;
      pneg_in = ctl.neg;

      ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      case (psh_ff)
         SHIFT_NONE: addend = ext;
         SHIFT_HALF: addend = ext <<< HALF_W;
         SHIFT_FULL: addend = ext <<< (2 * HALF_W);
         default:    addend = '0;
      endcase
      if (pdbl_ff) begin
         addend = addend <<< 1;
      end

      // The accumulator starts at minus the previous term scaled up, so that the
      // products simply add into the exact numerator.
      load_ext = {{(ACC_W-VAL_W){ctl.load_prev[VAL_W-1]}}, ctl.load_prev} <<< FRAC_BITS;

      acc_in = acc_ff;
      if (ctl.load) begin
         acc_in = -load_ext;
      end else if (pvld_ff) begin
         acc_in = pneg_ff ? acc_ff - addend : acc_ff + addend;
      end

      shifted   = acc_ff >>> FRAC_BITS;
      top_bits  = shifted[ACC_W-1:VAL_W-1];
      fin.sat   = !((&top_bits) || !(|top_bits));
      fin.value = fin.sat ? (acc_ff[ACC_W-1] ? VAL_MIN : VAL_MAX) : shifted[VAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= pvld_in;
      end
      prod_ff <= prod_in;
      psh_ff  <= psh_in;
      pdbl_ff <= pdbl_in;
      pneg_ff <= pneg_in;
      acc_ff  <= acc_in;
   end

endmodule

/* rtl/complex_chebyshev_evaluator.sv */
// Top level of the complex Chebyshev evaluator: APB register file, request capture and the
// sequencer that drives the shared multiply-accumulate unit. Depends on cce_pkg and cce_mac.
//
// Usage. A request (one complex point z, Q8.24) is taken at a rising edge where start is
// high and busy is low. The block maps it to x = scale*z - offset and runs the recurrence
// T(k+1) = 2x*T(k) - T(k-1) n times, n being the iteration count register clamped to
// MAX_ORDER. The result T(n+1)(x) in Q24.24, with a sticky overflow flag, appears on
// rsp_payload for exactly one cycle with rsp_valid high; the receiver cannot stall it, so
// it must take the result in that cycle.
// Datapath. Every 48x48 product is built from four partial products on a single
// registered 25x25 multiplier, one partial per cycle. Each mapped component issues its
// partials, then passes through a drain and a finish state; each recurrence component issues
// the partials of its two products and then passes through the same two states. rsp_valid
// rises at the edge where busy falls, so a new request may be accepted while the result is
// shown. One request is in flight at a time.
// Reset (synchronous, active high) returns the sequencer to idle, drops any request in
// flight and loads the register reset values. Registers must only be written while idle.
module complex_chebyshev_evaluator
   import cce_pkg::*;
#(
   parameter int MAX_ORDER = 1023,
   parameter int FRAC_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  req_payload_type       req_payload,
   // result channel
   output logic                  rsp_valid,
   output rsp_payload_type       rsp_payload,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_W-1:0]     paddr,
   input  logic [DATA_W-1:0]     pwdata,
   output logic [DATA_W-1:0]     prdata,
   output logic                  pready
);

   // The count register is ten bits wide, so the clamp limit never needs more.
   localparam int unsigned MaxCnt = (MAX_ORDER < 1023) ? MAX_ORDER : 1023;
   localparam logic signed [VAL_W-1:0] One = VAL_W'(1) << FRAC_BITS;
   localparam logic [2:0] MapLast  = 3'd3;
   localparam logic [2:0] StepLast = 3'd7;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_DRAIN,
      S_FINISH
   } state_type;

   // Which component the accumulator is currently building.
   typedef enum logic [1:0] {
      JOB_MAP_RE,
      JOB_MAP_IM,
      JOB_STEP_RE,
      JOB_STEP_IM
   } job_type;

   function automatic logic signed [VAL_W-1:0] widen(input logic signed [IN_W-1:0] v);
      widen = {{(VAL_W-IN_W){v[IN_W-1]}}, v};
   endfunction

   // Low half is unsigned, high half carries the sign: a = hi*2^24 + lo.
   function automatic logic signed [PART_W-1:0] lo_half(input logic signed [VAL_W-1:0] v);
      lo_half = {1'b0, v[HALF_W-1:0]};
   endfunction

   function automatic logic signed [PART_W-1:0] hi_half(input logic signed [VAL_W-1:0] v);
      hi_half = {v[VAL_W-1], v[VAL_W-1:HALF_W]};
   endfunction

   // Register file.
   logic signed [IN_W-1:0] scale_ff;
   logic signed [IN_W-1:0] offset_ff;
   logic [CNT_W-1:0]       count_ff;
   logic                   cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_RESET;
         offset_ff <= OFFSET_RESET;
         count_ff  <= COUNT_RESET;
      end else if (cfg_wr) begin
         case (reg_index_type'(paddr[3:2]))
            REG_SCALE:  scale_ff  <= pwdata;
            REG_OFFSET: offset_ff <= pwdata;
            REG_COUNT:  count_ff  <= pwdata[CNT_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(paddr[3:2]))
         REG_SCALE:  prdata = scale_ff;
         REG_OFFSET: prdata = offset_ff;
         REG_COUNT:  prdata = {{(DATA_W-CNT_W){1'b0}}, count_ff};
         default:    prdata = '0;
      endcase
   end

   // Sequencer state and datapath registers.
   state_type               state_ff, state_in;
   job_type                 job_ff, job_in;
   logic [2:0]              part_ff, part_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [IN_W-1:0]  zr_ff, zr_in, zi_ff, zi_in;
   logic signed [VAL_W-1:0] xr_ff, xr_in, xi_ff, xi_in;
   logic signed [VAL_W-1:0] tr_ff, tr_in, ti_ff, ti_in;
   logic signed [VAL_W-1:0] pi_ff, pi_in;
   logic signed [VAL_W-1:0] nr_ff, nr_in;
   logic                    ovf_ff, ovf_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_ff, rsp_in;

   logic                    accept;
   logic [CNT_W-1:0]        n_clamped;
   logic [CNT_W-1:0]        cnt_next;
   logic [2:0]              last_part;
   logic signed [VAL_W-1:0] op_a, op_b;
   logic                    op_neg;
   mac_ctl_type             mac_ctl;
   fin_type                 fin;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign n_clamped = (count_ff > CNT_W'(MaxCnt)) ? CNT_W'(MaxCnt) : count_ff;
   assign cnt_next  = cnt_ff + CNT_W'(1);
   assign last_part = (job_ff == JOB_MAP_RE || job_ff == JOB_MAP_IM) ? MapLast : StepLast;

   // Operand selection: bit 2 of the partial counter picks the term of the complex
   // product, bits 1 and 0 pick the halves of the two operands.
   always_comb begin
      op_neg = 1'b0;
      case (job_ff)
         JOB_MAP_RE: begin
            op_a = widen(scale_ff);
            op_b = widen(zr_ff);
         end
         JOB_MAP_IM: begin
            op_a = widen(scale_ff);
            op_b = widen(zi_ff);
         end
         JOB_STEP_RE: begin
            op_a   = part_ff[2] ? xi_ff : xr_ff;
            op_b   = part_ff[2] ? ti_ff : tr_ff;
            op_neg = part_ff[2];
         end
         JOB_STEP_IM: begin
            op_a = part_ff[2] ? xi_ff : xr_ff;
            op_b = part_ff[2] ? tr_ff : ti_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      part_in      = part_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      xr_in        = xr_ff;
      xi_in        = xi_ff;
      tr_in        = tr_ff;
      ti_in        = ti_ff;
      pi_in        = pi_ff;
      nr_in        = nr_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      mac_ctl.issue     = 1'b0;
      mac_ctl.load      = 1'b0;
      mac_ctl.load_prev = '0;
      mac_ctl.a_half    = part_ff[1] ? hi_half(op_a) : lo_half(op_a);
      mac_ctl.b_half    = part_ff[0] ? hi_half(op_b) : lo_half(op_b);
      case (part_ff[1:0])
         2'd0:    mac_ctl.shift_sel = SHIFT_NONE;
         2'd3:    mac_ctl.shift_sel = SHIFT_FULL;
         default: mac_ctl.shift_sel = SHIFT_HALF;
      endcase
      mac_ctl.dbl = (job_ff == JOB_STEP_RE || job_ff == JOB_STEP_IM);
      mac_ctl.neg = op_neg;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               zr_in             = req_payload.point_real;
               zi_in             = req_payload.point_imag;
               n_in              = n_clamped;
               ovf_in            = 1'b0;
               job_in            = JOB_MAP_RE;
               part_in           = '0;
               state_in          = S_ISSUE;
               mac_ctl.load      = 1'b1;
               mac_ctl.load_prev = widen(offset_ff);
            end
         end
         S_ISSUE: begin
            mac_ctl.issue = 1'b1;
            if (part_ff == last_part) begin
               state_in = S_DRAIN;
            end else begin
               part_in = part_ff + 3'd1;
            end
         end
         S_DRAIN: begin
            // The last partial product is added into the accumulator here.
            state_in = S_FINISH;
         end
         S_FINISH: begin
            ovf_in   = ovf_ff || fin.sat;
            part_in  = '0;
            state_in = S_ISSUE;
            case (job_ff)
               JOB_MAP_RE: begin
                  xr_in        = fin.value;
                  tr_in        = fin.value;
                  job_in       = JOB_MAP_IM;
                  mac_ctl.load = 1'b1;
               end
               JOB_MAP_IM: begin
                  xi_in  = fin.value;
                  ti_in  = fin.value;
                  pi_in  = '0;
                  cnt_in = '0;
                  if (n_ff == '0) begin
                     // With no steps the result is the mapped point itself.
                     rsp_valid_in         = 1'b1;
                     rsp_in.value_real    = tr_ff;
                     rsp_in.value_imag    = fin.value;
                     rsp_in.overflow_flag = ovf_ff || fin.sat;
                     state_in             = S_IDLE;
                  end else begin
                     job_in            = JOB_STEP_RE;
                     mac_ctl.load      = 1'b1;
                     mac_ctl.load_prev = One;
                  end
               end
               JOB_STEP_RE: begin
                  nr_in             = fin.value;
                  job_in            = JOB_STEP_IM;
                  mac_ctl.load      = 1'b1;
                  mac_ctl.load_prev = pi_ff;
               end
               JOB_STEP_IM: begin
                  pi_in  = ti_ff;
                  tr_in  = nr_ff;
                  ti_in  = fin.value;
                  cnt_in = cnt_next;
                  if (cnt_next == n_ff) begin
                     rsp_valid_in         = 1'b1;
                     rsp_in.value_real    = nr_ff;
                     rsp_in.value_imag    = fin.value;
                     rsp_in.overflow_flag = ovf_ff || fin.sat;
                     state_in             = S_IDLE;
                  end else begin
                     // The current T becomes the previous term of the next step.
                     job_in            = JOB_STEP_RE;
                     mac_ctl.load      = 1'b1;
                     mac_ctl.load_prev = tr_ff;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         job_ff       <= JOB_MAP_RE;
         part_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         part_ff      <= part_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff   <= n_in;
      zr_ff  <= zr_in;
      zi_ff  <= zi_in;
      xr_ff  <= xr_in;
      xi_ff  <= xi_in;
      tr_ff  <= tr_in;
      ti_ff  <= ti_in;
      pi_ff  <= pi_in;
      nr_ff  <= nr_in;
      ovf_ff <= ovf_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   cce_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .fin   (fin)
   );

   // An accepted request always leaves the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // Work only ends by delivering a result, unless reset cut it short.
   a_result_ends_work: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy fell without a result");

   // A result strobe lasts a single cycle.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // The result is shown only once the sequencer is idle again.
   a_strobe_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

endmodule
